// File: src/assert_macros.svh
// Assertion macros used by the top level of the hash set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Property that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

// File: src/lphs_pkg.sv
// Package with the types and constants of the linear probing hash set.
package lphs_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int HASH_W   = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int SIZE_W   = 7;
   localparam int DIV_CNT_W = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index as seen in bit 2 of the byte address.
   localparam logic CSR_TABLE_SIZE = 1'b0;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_FILLED  = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_PRESENT   = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIVIDE,
      S_PRIME,
      S_PROBE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic div_step;
      logic prime;
      logic probe_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic probe_end;
      logic out_free;
   } sts_type;

endpackage

// File: src/lphs_if.sv
// Channel interfaces for requests and responses of the hash set.
interface lphs_req_if;
   import lphs_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [KEY_W-1:0]  key;
   logic [HASH_W-1:0] hash_value;

   modport source (output valid, output op, output key, output hash_value, input ready);
   modport sink (input valid, input op, input key, input hash_value, output ready);
endinterface

interface lphs_rsp_if;
   import lphs_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic [SLOT_W-1:0]   slot_index;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;
   logic [KEY_W-1:0]    found_key;

   modport source (output valid, output hit, output slot_index, output status,
                   output entry_count, output found_key, input ready);
   modport sink (input valid, input hit, input slot_index, input status,
                 input entry_count, input found_key, output ready);
endinterface

// File: src/lphs_ram.sv
// Generic simple dual-port RAM with a registered read port.
module lphs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/lphs_ctrl.sv
// Controller state machine that sequences clearing, modulo, probing and commit.
module lphs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lphs_pkg::sts_type sts,
   output lphs_pkg::cmd_type cmd
);
   import lphs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_PRIME;
            end
         end
         S_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe_step = 1'b1;
            if (sts.probe_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end
endmodule

// File: src/lphs_dp.sv
// Datapath: hash reduction, probe walk over the slot memories, commit and result register.
module lphs_dp #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lphs_pkg::cmd_type               cmd,
   output lphs_pkg::sts_type               sts,
   input  logic [lphs_pkg::SIZE_W-1:0]     table_size,
   input  logic [lphs_pkg::OP_W-1:0]       req_op,
   input  logic [lphs_pkg::KEY_W-1:0]      req_key,
   input  logic [lphs_pkg::HASH_W-1:0]     req_hash_value,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic [lphs_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic [lphs_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lphs_pkg::COUNT_W-1:0]    rsp_entry_count,
   output logic [lphs_pkg::KEY_W-1:0]      rsp_found_key
);
   import lphs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int PW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;

   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                               input logic [SIZE_W-1:0] s);
      logic [PW-1:0] nxt;
      nxt = PW'(p) + PW'(1);
      if (nxt >= PW'(s)) begin
         return '0;
      end
      return AW'(nxt);
   endfunction

   // Effective number of slots in use.
   logic [SIZE_W-1:0] size_eff;
   always_comb begin
      if (table_size == '0) begin
         size_eff = SIZE_W'(1);
      end else if (PW'(table_size) > PW'(DEPTH)) begin
         size_eff = SIZE_W'(DEPTH);
      end else begin
         size_eff = table_size;
      end
   end

   // Item registers.
   logic [OP_W-1:0]      op_ff;
   logic [KEY_WIDTH-1:0] key_ff;

   // Restoring remainder unit, one hash bit per cycle.
   logic [HASH_W-1:0]    div_hash_ff;
   logic [SIZE_W-1:0]    rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [SIZE_W:0]      trial;
   logic [SIZE_W-1:0]    rem_in;

   always_comb begin
      trial = {rem_ff, div_hash_ff[HASH_W-1]};
      if (trial >= {1'b0, size_eff}) begin
         rem_in = SIZE_W'(trial - {1'b0, size_eff});
      end else begin
         rem_in = SIZE_W'(trial);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_op;
         key_ff      <= KEY_WIDTH'(req_key);
         div_hash_ff <= req_hash_value;
         rem_ff      <= '0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         div_hash_ff <= {div_hash_ff[HASH_W-2:0], 1'b0};
         rem_ff      <= rem_in;
         div_cnt_ff  <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   assign sts.div_last = (div_cnt_ff == DIV_CNT_W'(HASH_W - 1));

   // Probe walk: the read address runs one slot ahead of the slot evaluated.
   logic [AW-1:0]     pos_ff;
   logic [AW-1:0]     eval_pos_ff;
   logic [SIZE_W-1:0] step_ff;
   logic              tomb_seen_ff;
   logic [AW-1:0]     tomb_ff;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     start_pos;
   logic [1:0]        mark_rd;
   logic [KEY_WIDTH-1:0] key_rd;

   logic is_empty, is_match, is_del, last_step;
   logic tomb_now_seen;
   logic [AW-1:0] tomb_now;

   assign start_pos = AW'(rem_ff);
   assign rd_addr   = cmd.prime ? start_pos : pos_ff;

   always_comb begin
      is_empty      = (mark_rd == MARK_EMPTY);
      is_match      = (mark_rd == MARK_FILLED) && (key_rd == key_ff);
      is_del        = (mark_rd == MARK_DELETED);
      last_step     = (step_ff == size_eff - SIZE_W'(1));
      tomb_now_seen = tomb_seen_ff | is_del;
      tomb_now      = tomb_seen_ff ? tomb_ff : eval_pos_ff;
   end

   assign sts.probe_end = is_empty | is_match | last_step;

   logic          hit_ff;
   logic          free_ok_ff;
   logic [AW-1:0] slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.prime) begin
         eval_pos_ff  <= start_pos;
         pos_ff       <= next_pos(start_pos, size_eff);
         step_ff      <= '0;
         tomb_seen_ff <= 1'b0;
      end else if (cmd.probe_step) begin
         eval_pos_ff  <= pos_ff;
         pos_ff       <= next_pos(pos_ff, size_eff);
         step_ff      <= step_ff + SIZE_W'(1);
         tomb_seen_ff <= tomb_now_seen;
         if (is_del && !tomb_seen_ff) begin
            tomb_ff <= eval_pos_ff;
         end
         if (sts.probe_end) begin
            hit_ff     <= is_match;
            free_ok_ff <= is_empty | tomb_now_seen;
            slot_ff    <= is_match ? eval_pos_ff : tomb_now;
         end
      end
   end

   // Clearing pass over the slot marks after reset.
   logic [AW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end
   assign sts.clear_last = (clr_ff == AW'(DEPTH - 1));

   // Commit of the operation.
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               mark_wr, key_wr;
   mark_type           mark_val;
   status_type         status_val;
   logic [AW-1:0]      slot_val;
   logic [KEY_W-1:0]   fkey_val;

   always_comb begin
      count_in   = count_ff;
      mark_wr    = 1'b0;
      key_wr     = 1'b0;
      mark_val   = MARK_FILLED;
      slot_val   = '0;
      fkey_val   = '0;
      status_val = STAT_NOT_FOUND;
      case (op_ff)
         OP_ADD: begin
            if (hit_ff) begin
               slot_val   = slot_ff;
               status_val = STAT_PRESENT;
            end else if (free_ok_ff) begin
               mark_wr    = 1'b1;
               key_wr     = 1'b1;
               slot_val   = slot_ff;
               status_val = STAT_DONE;
               if (count_ff < COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end else begin
               status_val = STAT_FULL;
            end
         end
         OP_REMOVE: begin
            if (hit_ff) begin
               mark_wr    = 1'b1;
               mark_val   = MARK_DELETED;
               slot_val   = slot_ff;
               status_val = STAT_DONE;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
         end
         default: begin
            if (hit_ff) begin
               slot_val   = slot_ff;
               fkey_val   = KEY_W'(key_ff);
               status_val = STAT_DONE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= count_in;
      end
   end

   // Slot memories.
   logic          mark_we;
   logic [AW-1:0] mark_wa;
   logic [1:0]    mark_wd;

   assign mark_we = cmd.clear_step | (cmd.finish & mark_wr);
   assign mark_wa = cmd.clear_step ? clr_ff : slot_ff;
   assign mark_wd = cmd.clear_step ? MARK_EMPTY : mark_val;

   lphs_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (rd_addr),
      .rd_data (mark_rd)
   );

   lphs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.finish & key_wr),
      .wr_addr (slot_ff),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   // Result register.
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [KEY_W-1:0]    rsp_fkey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hit_ff    <= hit_ff;
         rsp_slot_ff   <= SLOT_W'(slot_val);
         rsp_status_ff <= status_val;
         rsp_count_ff  <= count_in;
         rsp_fkey_ff   <= fkey_val;
      end
   end

   assign sts.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_found_key   = rsp_fkey_ff;
endmodule

// File: src/linear_probe_hash_set_top.sv
// Top level of the linear probing hash set with its register port.
//
//   Channel   Direction  Transfer rule                 Carries
//   req_ch    in         valid and ready high          op, key, hash_value
//   rsp_ch    out        valid and ready high          hit, slot_index, status,
//                                                      entry_count, found_key
//   csr_*     in/out     psel, penable, pwrite, pready table_size at address 0
//
// A transaction runs from acceptance to the result register through a load step, the
// bit-serial remainder unit that reduces the hash, a step to prime the registered
// memory read, the probe walk, which evaluates one slot a cycle and probes from 1 up to
// the effective table size of slots, and a final commit step.
// After reset a clearing pass writes every slot mark to empty, during which no request
// is taken; register writes are taken throughout.
// A stalled response holds in the result register while the next request is already
// taken; only its commit waits for the register to drain.
module linear_probe_hash_set_top #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   lphs_req_if.sink          req_ch,
   lphs_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import lphs_pkg::*;

   `include "assert_macros.svh"

   // The table size register. Its low seven bits are kept, and a write is taken on the
   // access phase of the transfer. Bit 2 of the byte address selects the register, so
   // anything beyond the first word is ignored on write and reads back as zero.
   logic [SIZE_W-1:0] table_size_ff;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_TABLE_SIZE)) begin
         table_size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_TABLE_SIZE) begin
         csr_prdata = CSR_DATA_W'(table_size_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // The controller decides what happens in each cycle; the datapath holds the item,
   // the remainder unit, the probe walk, the slot memories and the result register.
   cmd_type cmd;
   sts_type sts;

   lphs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lphs_dp #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .table_size      (table_size_ff),
      .req_op          (req_ch.op),
      .req_key         (req_ch.key),
      .req_hash_value  (req_ch.hash_value),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_hit         (rsp_ch.hit),
      .rsp_slot_index  (rsp_ch.slot_index),
      .rsp_status      (rsp_ch.status),
      .rsp_entry_count (rsp_ch.entry_count),
      .rsp_found_key   (rsp_ch.found_key)
   );

   // The controller never issues two commands in the same cycle.
   `ASSERT_ALWAYS(a_one_cmd, clock, reset,
      $onehot0({cmd.clear_step, cmd.load, cmd.div_step, cmd.prime, cmd.probe_step, cmd.finish}),
      "more than one datapath command at once")

   // A commit only happens when the result register can take it.
   `ASSERT_SAME(a_commit_free, clock, reset, cmd.finish, sts.out_free,
      "commit while the result register is still occupied")

   // Once a request is taken, no further request is taken until it has been committed.
   `ASSERT_NEXT(a_one_item, clock, reset, cmd.load, !req_ch.ready,
      "request accepted while another is in progress")

   // A full table is only reported for a miss, with no slot.
   `ASSERT_SAME(a_full_miss, clock, reset,
      rsp_ch.valid && (rsp_ch.status == STAT_FULL),
      !rsp_ch.hit && (rsp_ch.slot_index == '0),
      "table full reported together with a hit or a slot")
endmodule

// File: tb/linear_probe_hash_set_top_tb.sv
// Self-checking testbench for the linear probing hash set: directed and random transactions.
module linear_probe_hash_set_top_tb;
   import lphs_pkg::*;

   localparam int DEPTH         = 64;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 120;

   // Byte address of the table size register.
   localparam logic [CSR_ADDR_W-1:0] TABLE_SIZE_ADDR = {CSR_TABLE_SIZE, 2'b00};
   // Operation code with no function of its own; the block treats it as a find.
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // What one response transaction should carry.
   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot_index;
      status_type          status;
      logic [COUNT_W-1:0]  entry_count;
      logic [KEY_W-1:0]    found_key;
   } set_outcome_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   lphs_req_if req_if ();
   lphs_rsp_if rsp_if ();

   linear_probe_hash_set_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The testbench's own copy of the set: slot marks, stored keys, the number of filled
   // slots and the table size register as last written.
   mark_type           slot_mark_copy [DEPTH];
   logic [KEY_W-1:0]   slot_key_copy [DEPTH];
   logic [COUNT_W-1:0] filled_slots;
   logic [SIZE_W-1:0]  table_size_setting;

   set_outcome_type pending_outcomes [$];
   int           error_count = 0;
   int           idle_cycles = 0;
   int           stall_left  = 0;
   bit           quiet_mode  = 1'b0;

   // Gap length for either side: mostly none, sometimes a few cycles, now and then a long
   // one. While quiet_mode is set both sides run flat out.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Applies one operation to the local copy of the set and returns the response it
   // should produce. The probe starts at hash mod the effective size and walks one slot
   // at a time with wrap-around; it ends at an empty slot, at a filled slot holding the
   // key, or after a whole lap. The first tombstone passed is remembered so that an add
   // can reuse it.
   function automatic set_outcome_type apply_set_op(input logic [OP_W-1:0]   op,
                                                    input logic [KEY_W-1:0]  key,
                                                    input logic [HASH_W-1:0] hash);
      set_outcome_type res;
      int unsigned  span, pos, tomb, match_slot, free_slot, i;
      bit           tomb_seen, matched, has_free, stop;
      res        = '0;
      tomb_seen  = 1'b0;
      matched    = 1'b0;
      has_free   = 1'b0;
      stop       = 1'b0;
      tomb       = 0;
      match_slot = 0;
      free_slot  = 0;
      // A size of zero behaves as one slot; anything beyond the depth is clipped.
      if (table_size_setting == 0)
         span = 1;
      else if (table_size_setting > DEPTH)
         span = DEPTH;
      else
         span = table_size_setting;
      pos = hash % span;
      for (i = 0; i < span && !stop; i++) begin
         if (slot_mark_copy[pos] == MARK_EMPTY) begin
            has_free  = 1'b1;
            free_slot = tomb_seen ? tomb : pos;
            stop      = 1'b1;
         end else if (slot_mark_copy[pos] == MARK_FILLED && slot_key_copy[pos] == key) begin
            matched    = 1'b1;
            match_slot = pos;
            stop       = 1'b1;
         end else begin
            if (slot_mark_copy[pos] == MARK_DELETED && !tomb_seen) begin
               tomb_seen = 1'b1;
               tomb      = pos;
            end
            pos = (pos + 1 == span) ? 0 : pos + 1;
         end
      end
      // A lap without an empty slot may still leave a tombstone for an add.
      if (!stop && tomb_seen) begin
         has_free  = 1'b1;
         free_slot = tomb;
      end
      res.hit = matched;
      case (op)
         OP_ADD: begin
            if (matched) begin
               res.slot_index = match_slot[SLOT_W-1:0];
               res.status     = STAT_PRESENT;
            end else if (has_free) begin
               slot_mark_copy[free_slot] = MARK_FILLED;
               slot_key_copy[free_slot]  = key;
               filled_slots++;
               res.slot_index = free_slot[SLOT_W-1:0];
               res.status     = STAT_DONE;
            end else begin
               res.status = STAT_FULL;
            end
         end
         OP_REMOVE: begin
            if (matched) begin
               slot_mark_copy[match_slot] = MARK_DELETED;
               filled_slots--;
               res.slot_index = match_slot[SLOT_W-1:0];
               res.status     = STAT_DONE;
            end else begin
               res.status = STAT_NOT_FOUND;
            end
         end
         default: begin
            // Find, and the spare code, which behaves as a find.
            if (matched) begin
               res.slot_index = match_slot[SLOT_W-1:0];
               res.found_key  = slot_key_copy[match_slot];
               res.status     = STAT_DONE;
            end else begin
               res.status = STAT_NOT_FOUND;
            end
         end
      endcase
      res.entry_count = filled_slots;
      return res;
   endfunction

   // Offers one request transaction after a random gap and records its expected response
   // once the block has accepted it. Valid is left high so that the next call can follow
   // back to back; stop_sending lowers it whenever anything else is to happen.
   task automatic send_item(input logic [OP_W-1:0]   op,
                            input logic [KEY_W-1:0]  key,
                            input logic [HASH_W-1:0] hash);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.op         = op;
      req_if.key        = key;
      req_if.hash_value = hash;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_outcomes.push_back(apply_set_op(op, key, hash));
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   // Holds the request side back until every expected response has come in, which leaves
   // the block idle since each transaction yields exactly one response.
   task automatic drain_results();
      stop_sending();
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Writes the table size register, then reads it back.
   task automatic write_table_size(input logic [SIZE_W-1:0] size);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = TABLE_SIZE_ADDR;
      csr_pwdata  = 32'(size);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      table_size_setting = size;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[SIZE_W-1:0] !== size) begin
         $error("table_size readback: expected %0d, got %0d", size, csr_prdata[SIZE_W-1:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Every operation at the default size of 64 slots: a collision chain at slot 5,
   // tombstone creation and reuse, misses, the spare code and the extreme keys and hashes.
   task automatic test_basic_operations();
      send_item(OP_ADD,    32'h1234_5678, 32'd5);
      send_item(OP_ADD,    32'h1234_5678, 32'd5);
      send_item(OP_FIND,   32'h1234_5678, 32'd5);
      send_item(OP_FIND,   32'hDEAD_BEEF, 32'd5);
      send_item(OP_REMOVE, 32'hDEAD_BEEF, 32'd5);
      send_item(OP_SPARE,  32'h1234_5678, 32'd5);
      send_item(OP_ADD,    32'hDEAD_BEEF, 32'd5);
      send_item(OP_REMOVE, 32'h1234_5678, 32'd5);
      send_item(OP_FIND,   32'hDEAD_BEEF, 32'd5);
      send_item(OP_ADD,    32'hC0FF_EE00, 32'd5);
      send_item(OP_ADD,    32'h0000_0000, 32'h0000_0000);
      send_item(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_FIND,   32'hFFFF_FFFF, 32'h0000_003F);
      drain_results();
   endtask

   // A one-slot table fills at once: the next add reports full, and after a remove the
   // tombstone found on the full lap is reused. Sizes of zero and above the depth are
   // then tried, as they must behave as one slot and as the full depth.
   task automatic test_full_lap_and_size_limits();
      write_table_size(7'd1);
      send_item(OP_ADD,    32'h1234_5678, 32'h8000_0001);
      send_item(OP_ADD,    32'h0000_0000, 32'h0000_0007);
      send_item(OP_REMOVE, 32'h1234_5678, 32'h0F0F_0F0F);
      send_item(OP_ADD,    32'h0000_0000, 32'h0000_0007);
      send_item(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
      drain_results();
      write_table_size(7'd0);
      send_item(OP_FIND,   32'h1234_5678, 32'h0000_0002);
      send_item(OP_ADD,    32'h0000_0000, 32'h0000_0000);
      drain_results();
      write_table_size(7'd127);
      send_item(OP_FIND,   32'h1234_5678, 32'h0000_0000);
      send_item(OP_REMOVE, 32'h1234_5678, 32'h0000_0040);
      drain_results();
   endtask

   // Shrinking the table leaves the slots beyond the new size filled: they are no longer
   // probed but still count towards the entry count.
   task automatic test_shrink_without_rehash();
      write_table_size(7'd4);
      send_item(OP_ADD,  32'hA5A5_5A5A, 32'd2);
      send_item(OP_FIND, 32'hDEAD_BEEF, 32'd6);
      drain_results();
   endtask

   // One phase of random traffic at one table size. Keys come from a small pool, each
   // with a fixed hash, so that adds, removes and finds keep meeting each other; a few
   // transactions carry a fresh key or a stray hash. Half-way through, the sender waits
   // for every outstanding response before it goes on.
   task automatic run_random_traffic(input logic [SIZE_W-1:0] size, input int n_items,
                                     input int pool_size, input bit calm);
      logic [KEY_W-1:0]  pool_key [$];
      logic [HASH_W-1:0] pool_hash [$];
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
      int                r, pick;
      drain_results();
      write_table_size(size);
      quiet_mode = calm;
      for (int i = 0; i < pool_size; i++) begin
         pool_key.push_back($urandom);
         pool_hash.push_back($urandom);
      end
      for (int i = 0; i < n_items; i++) begin
         r  = $urandom_range(0, 99);
         op = (r < 45) ? OP_ADD : (r < 70) ? OP_REMOVE : (r < 95) ? OP_FIND : OP_SPARE;
         pick = $urandom_range(0, pool_size - 1);
         key  = pool_key[pick];
         hash = pool_hash[pick];
         if ($urandom_range(0, 19) == 0)
            key = $urandom;
         if ($urandom_range(0, 9) == 0)
            hash = $urandom;
         if (i == n_items / 2)
            drain_results();
         send_item(op, key, hash);
      end
      quiet_mode = 1'b0;
   endtask

   // Sizes from one slot to beyond the depth; the large pool at full depth fills the
   // table so that full and tombstone-reuse cases turn up there too.
   task automatic test_random_traffic();
      run_random_traffic(7'd64,  250, 12, 1'b0);
      run_random_traffic(7'd5,   250,  8, 1'b0);
      run_random_traffic(7'd1,   100,  3, 1'b1);
      run_random_traffic(7'd17,  300, 24, 1'b0);
      run_random_traffic(7'd2,   150,  4, 1'b0);
      run_random_traffic(7'd127, 300, 80, 1'b0);
      run_random_traffic(7'd0,    60,  3, 1'b0);
      run_random_traffic(7'd40,  250, 30, 1'b1);
      run_random_traffic(7'd64,  150, 16, 1'b0);
   endtask

   // The response side: ready drops now and then for a random stretch.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready = 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // Each accepted response is compared field by field with the oldest expectation.
   always @(posedge clock) begin : check_responses
      set_outcome_type exp;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $error("response transaction arrived with none expected");
            error_count++;
         end else begin
            exp = pending_outcomes.pop_front();
            if (rsp_if.hit !== exp.hit) begin
               $error("hit: expected %0d, got %0d", exp.hit, rsp_if.hit);
               error_count++;
            end
            if (rsp_if.slot_index !== exp.slot_index) begin
               $error("slot_index: expected %0d, got %0d", exp.slot_index, rsp_if.slot_index);
               error_count++;
            end
            if (rsp_if.status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.entry_count !== exp.entry_count) begin
               $error("entry_count: expected %0d, got %0d", exp.entry_count,
                      rsp_if.entry_count);
               error_count++;
            end
            if (rsp_if.found_key !== exp.found_key) begin
               $error("found_key: expected %h, got %h", exp.found_key, rsp_if.found_key);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any transaction on either channel or the register port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.op         = OP_ADD;
      req_if.key        = '0;
      req_if.hash_value = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      for (int i = 0; i < DEPTH; i++) begin
         slot_mark_copy[i] = MARK_EMPTY;
         slot_key_copy[i]  = '0;
      end
      filled_slots       = '0;
      table_size_setting = TABLE_SIZE_RESET;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // The clearing pass after reset needs no wait of its own: the first request simply
      // waits for ready.
      test_basic_operations();
      test_full_lap_and_size_limits();
      test_shrink_without_rehash();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d response transactions never arrived", pending_outcomes.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
